>>> hdl/sbpa_pkg.sv
package sbpa_pkg;

  // table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // payload widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned COUNT_W = 35;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_CMP = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_e;

endpackage

>>> hdl/sbpa_if.sv
interface sbpa_req_if;
  import sbpa_pkg::*;

  logic              valid;
  logic              ready;
  mode_e             mode;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] byte_size;

  modport source (output valid, output mode, output address, output byte_size, input ready);
  modport sink   (input valid, input mode, input address, input byte_size, output ready);
endinterface

interface sbpa_rsp_if;
  import sbpa_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic [ADDR_W-1:0]  granted_address;
  logic [COUNT_W-1:0] free_bytes;
  logic [COUNT_W-1:0] total_bytes;

  modport source (output valid, output status, output granted_address, output free_bytes,
                  output total_bytes, input ready);
  modport sink   (input valid, input status, input granted_address, input free_bytes,
                  input total_bytes, output ready);
endinterface

>>> hdl/sbpa_alu.sv
module sbpa_alu (
  input  sbpa_pkg::alu_op_e                op_i,
  input  logic [sbpa_pkg::COUNT_W-1:0]     a_i,
  input  logic [sbpa_pkg::SIZE_W-1:0]      b_i,
  output logic [sbpa_pkg::COUNT_W-1:0]     res_o,
  output logic                             gt_o
);
  import sbpa_pkg::*;

  logic [COUNT_W:0] sum;
  logic [COUNT_W:0] diff;
  logic             borrow;

  // one adder and one subtractor, shared by the insert, scan and count-update steps of the sequencer
  assign sum    = {1'b0, a_i} + (COUNT_W + 1)'(b_i);
  assign diff   = {1'b0, a_i} - (COUNT_W + 1)'(b_i);
  assign borrow = diff[COUNT_W];

  // a greater than b: no borrow and a nonzero difference
  assign gt_o = !borrow && (diff[COUNT_W-1:0] != '0);

  always_comb begin
    case (op_i)
      ALU_ADD: res_o = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      ALU_SUB: res_o = borrow ? '0 : diff[COUNT_W-1:0];
      default: res_o = diff[COUNT_W-1:0];
    endcase
  end

endmodule

>>> hdl/sorted_buffer_pool_allocator.sv
// channel  dir  handshake          payload
// req_i    in   valid / ready      mode, address, byte_size
// rsp_o    out  valid / ready      status, granted_address, free_bytes, total_bytes
//
// one item at a time; req_i.ready is high only while the sequencer is idle
// load: insert pass walks down from the top, then total update, free update and response
// allocate / free: scan upward, then update free count if an entry changes, then respond
// clear goes straight to response; shared compare / add unit handles one entry per cycle
// the response sits in an output register, so rsp_o may stall while the next beat is taken
// rst_ni clears counts and in-use bits at once; no clearing pass
module sorted_buffer_pool_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbpa_req_if.sink   req_i,
  sbpa_rsp_if.source rsp_o
);
  import sbpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_ADD_TOTAL,
    S_UPD_FREE,
    S_RESP
  } state_e;

  // buffer table, kept sorted by ascending size
  logic [ADDR_W-1:0]  entry_addr_q [ENTRIES];
  logic [SIZE_W-1:0]  entry_size_q [ENTRIES];
  logic [ENTRIES-1:0] entry_used_q;
  logic [CNT_W-1:0]   count_q;
  logic [COUNT_W-1:0] total_q;
  logic [COUNT_W-1:0] free_q;

  // sequencer state and latched request
  state_e             state_q;
  mode_e              mode_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SIZE_W-1:0]  size_q;
  logic [CNT_W-1:0]   idx_q;      // scan pointer, or slot being filled on insert
  logic [SIZE_W-1:0]  op_size_q;  // operand for the count update
  logic               sub_q;      // count update subtracts (allocate)
  status_e            status_q;
  logic [ADDR_W-1:0]  grant_q;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [ADDR_W-1:0]  out_grant_q;
  logic [COUNT_W-1:0] out_free_q;
  logic [COUNT_W-1:0] out_total_q;

  logic [CNT_W-1:0]   idx_dec;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [ADDR_W-1:0]  addr_rd;
  logic [SIZE_W-1:0]  size_rd;
  logic               used_rd;
  logic               scan_end;
  logic               table_full;
  logic               insert_here;

  alu_op_e            alu_op;
  logic [COUNT_W-1:0] alu_a;
  logic [SIZE_W-1:0]  alu_b;
  logic [COUNT_W-1:0] alu_res;
  logic               alu_gt;

  // on insert the entry below the slot is read, otherwise the scanned entry
  assign idx_dec = idx_q - CNT_W'(1);
  assign rd_idx  = (state_q == S_INSERT) ? idx_dec[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign wr_idx  = idx_q[IDX_W-1:0];
  assign addr_rd = entry_addr_q[rd_idx];
  assign size_rd = entry_size_q[rd_idx];
  assign used_rd = entry_used_q[rd_idx];

  assign scan_end   = (idx_q == count_q);
  assign table_full = (count_q == CNT_W'(ENTRIES));

  // insertion walks down from the top; it stops just above the first entry whose
  // size is not larger, which keeps equal sizes in load order
  assign insert_here = (idx_q == '0) || !alu_gt;

  // operand selection for the shared unit
  always_comb begin
    case (state_q)
      S_INSERT: begin
        alu_op = ALU_CMP;
        alu_a  = COUNT_W'(size_rd);
        alu_b  = size_q;
      end
      S_SCAN: begin
        // request larger than entry means no fit
        alu_op = ALU_CMP;
        alu_a  = COUNT_W'(size_q);
        alu_b  = size_rd;
      end
      S_ADD_TOTAL: begin
        alu_op = ALU_ADD;
        alu_a  = total_q;
        alu_b  = op_size_q;
      end
      S_UPD_FREE: begin
        alu_op = sub_q ? ALU_SUB : ALU_ADD;
        alu_a  = free_q;
        alu_b  = op_size_q;
      end
      default: begin
        alu_op = ALU_CMP;
        alu_a  = free_q;
        alu_b  = op_size_q;
      end
    endcase
  end

  sbpa_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.granted_address = out_grant_q;
  assign rsp_o.free_bytes      = out_free_q;
  assign rsp_o.total_bytes     = out_total_q;

  // table address and size: shift up one slot per cycle, then drop in the new buffer
  always_ff @(posedge clk_i) begin
    if (state_q == S_INSERT) begin
      if (insert_here) begin
        entry_addr_q[wr_idx] <= addr_q;
        entry_size_q[wr_idx] <= size_q;
      end else begin
        entry_addr_q[wr_idx] <= addr_rd;
        entry_size_q[wr_idx] <= size_rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_LOAD;
      addr_q       <= '0;
      size_q       <= '0;
      idx_q        <= '0;
      op_size_q    <= '0;
      sub_q        <= 1'b0;
      status_q     <= ST_OK;
      grant_q      <= '0;
      entry_used_q <= '0;
      count_q      <= '0;
      total_q      <= '0;
      free_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_grant_q  <= '0;
      out_free_q   <= '0;
      out_total_q  <= '0;
    end else begin
      // the response state refills the output register itself
      if (rsp_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q  <= req_i.mode;
            addr_q  <= req_i.address;
            size_q  <= req_i.byte_size;
            grant_q <= '0;
            case (req_i.mode)
              MODE_LOAD: begin
                if (table_full) begin
                  status_q <= ST_TABLE_FULL;
                  idx_q    <= '0;
                  state_q  <= S_RESP;
                end else begin
                  status_q <= ST_OK;
                  idx_q    <= count_q;
                  state_q  <= S_INSERT;
                end
              end
              MODE_ALLOC, MODE_FREE: begin
                status_q <= ST_OK;
                idx_q    <= '0;
                state_q  <= S_SCAN;
              end
              default: begin
                // clear: empty table, zero both counts
                status_q     <= ST_OK;
                idx_q        <= '0;
                entry_used_q <= '0;
                count_q      <= '0;
                total_q      <= '0;
                free_q       <= '0;
                state_q      <= S_RESP;
              end
            endcase
          end
        end

        S_INSERT: begin
          if (insert_here) begin
            entry_used_q[wr_idx] <= 1'b0;
            count_q              <= count_q + CNT_W'(1);
            op_size_q            <= size_q;
            sub_q                <= 1'b0;
            state_q              <= S_ADD_TOTAL;
          end else begin
            entry_used_q[wr_idx] <= used_rd;
            idx_q                <= idx_dec;
          end
        end

        S_SCAN: begin
          if (scan_end) begin
            status_q <= (mode_q == MODE_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
            state_q  <= S_RESP;
          end else if (mode_q == MODE_ALLOC) begin
            // first free entry that fits is the smallest fit
            if (!used_rd && !alu_gt) begin
              entry_used_q[rd_idx] <= 1'b1;
              grant_q              <= addr_rd;
              op_size_q            <= size_rd;
              sub_q                <= 1'b1;
              state_q              <= S_UPD_FREE;
            end else begin
              idx_q <= idx_q + CNT_W'(1);
            end
          end else begin
            if (addr_rd == addr_q) begin
              if (used_rd) begin
                entry_used_q[rd_idx] <= 1'b0;
                op_size_q            <= size_rd;
                sub_q                <= 1'b0;
                state_q              <= S_UPD_FREE;
              end else begin
                // already free: nothing to release
                state_q <= S_RESP;
              end
            end else begin
              idx_q <= idx_q + CNT_W'(1);
            end
          end
        end

        S_ADD_TOTAL: begin
          total_q <= alu_res;
          state_q <= S_UPD_FREE;
        end

        S_UPD_FREE: begin
          free_q  <= alu_res;
          state_q <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_grant_q  <= grant_q;
            out_free_q   <= free_q;
            out_total_q  <= total_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sbpa_checker.sv
module sbpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input sbpa_pkg::status_e             rsp_status_i,
  input logic [sbpa_pkg::ADDR_W-1:0]   rsp_grant_i,
  input logic [sbpa_pkg::COUNT_W-1:0]  rsp_free_i,
  input logic [sbpa_pkg::COUNT_W-1:0]  rsp_total_i
);
  import sbpa_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_grant_i) && $stable(rsp_free_i) && $stable(rsp_total_i))
    else $error("response beat changed while stalled");

  // only a successful grant carries an address
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> rsp_grant_i == '0)
    else $error("address returned on a failed item");

  // free bytes never exceed the loaded total
  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_free_i <= rsp_total_i)
    else $error("free byte count above total");

endmodule

bind sorted_buffer_pool_allocator sbpa_checker u_sbpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_grant_i  (rsp_o.granted_address),
  .rsp_free_i   (rsp_o.free_bytes),
  .rsp_total_i  (rsp_o.total_bytes)
);
